@@ design/srle_pkg.sv @@
// ----------------------------------------------------------------------------
// srle_pkg: shared types and constants of the scanline RLE sprite decoder
// Result word layout, register indexes, result kinds and queue sizing.
// ----------------------------------------------------------------------------
package srle_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_STREAM_BYTES = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_RUN   = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // bytes of the per-row length prefix
  localparam logic [24:0] LEN_BYTES = 25'd2;

  // result queue: 8 entries, an item may push up to 3
  localparam int              QUEUE_AW        = 3;
  localparam int              QUEUE_CW        = 4;
  localparam logic [QUEUE_CW-1:0] QUEUE_ROOM_MAX = 4'd5;

  // out_tdata bit positions
  localparam int TD_PIX_LSB = 0;
  localparam int TD_COL_LSB = 29;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  pixel_value;
    logic [10:0] run_length;
    logic [9:0]  row;
    logic [9:0]  column;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [10:0] width;         // effective, clamped to the maximum
    logic [10:0] height;        // effective, clamped to the maximum
    logic [23:0] stream_bytes;
  } frame_cfg_t;

  typedef struct packed {
    logic [1:0]        count;   // 0..3 results from this word
    result_t [2:0]     res;     // packed in order, res[0] first
  } push_t;

endpackage

@@ design/srle_decode.sv @@
// ----------------------------------------------------------------------------
// srle_decode: per-byte decode step
// Holds the stream parse state and turns one accepted word into up to three
// result words in a single pass.
// ----------------------------------------------------------------------------
module srle_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  logic               mode,
  input  logic [7:0]         in_byte,
  input  srle_pkg::frame_cfg_t cfg,
  output srle_pkg::push_t    push
);
  import srle_pkg::*;

  typedef enum logic [1:0] {
    PH_LEN_LO    = 2'd0,
    PH_LEN_HI    = 2'd1,
    PH_PAYLOAD   = 2'd2,
    PH_RUN_COUNT = 2'd3
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [23:0] bpos_r, bpos_nxt;
  logic [23:0] lend_r, lend_nxt;
  logic [7:0]  lenlo_r, lenlo_nxt;
  logic [10:0] col_r, col_nxt;
  logic [10:0] row_r, row_nxt;
  logic        fin_r, fin_nxt;

  logic [23:0] bpos_inc;
  logic [15:0] len16, len_adj;
  logic [24:0] row_stop;
  logic [10:0] room, take, left;
  logic        need_end, need_start;
  logic        a_vld, b_vld, c_vld;
  result_t     res_a, res_b, res_c;
  logic [1:0]  n;

  always_comb begin
    phase_nxt  = phase_r;
    bpos_nxt   = bpos_r;
    lend_nxt   = lend_r;
    lenlo_nxt  = lenlo_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    fin_nxt    = fin_r;
    need_end   = 1'b0;
    need_start = 1'b0;
    a_vld      = 1'b0;
    b_vld      = 1'b0;
    c_vld      = 1'b0;
    res_a      = '0;
    res_b      = '0;
    res_c      = '0;
    left       = '0;

    bpos_inc = bpos_r + 24'd1;
    len16    = {in_byte, lenlo_r};
    len_adj  = (len16 >= 16'd2) ? (len16 - 16'd2) : 16'd0;
    row_stop = {1'b0, bpos_inc} + {9'd0, len_adj};
    room     = (col_r < cfg.width) ? (cfg.width - col_r) : 11'd0;
    take     = ({3'd0, in_byte} < room) ? {3'd0, in_byte} : room;

    if (acc) begin
      if (!mode) begin
        // new frame
        phase_nxt  = PH_LEN_LO;
        bpos_nxt   = '0;
        lend_nxt   = '0;
        lenlo_nxt  = '0;
        col_nxt    = '0;
        row_nxt    = '0;
        fin_nxt    = 1'b0;
        need_start = 1'b1;
      end else if (!fin_r) begin
        bpos_nxt = bpos_inc;
        case (phase_r)
          PH_LEN_LO: begin
            lenlo_nxt = in_byte;
            phase_nxt = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            if (row_stop > {1'b0, cfg.stream_bytes}) begin
              fin_nxt     = 1'b1;
              c_vld       = 1'b1;
              res_c.kind  = KIND_ERROR;
              res_c.row   = row_r[9:0];
            end else begin
              lend_nxt  = row_stop[23:0];
              phase_nxt = PH_PAYLOAD;
              need_end  = (bpos_inc >= row_stop[23:0]);
            end
          end
          PH_PAYLOAD: begin
            if (col_r < cfg.width) begin
              if (in_byte != 8'd0) begin
                a_vld             = 1'b1;
                res_a.kind        = KIND_RUN;
                res_a.pixel_value = in_byte;
                res_a.run_length  = 11'd1;
                res_a.row         = row_r[9:0];
                res_a.column      = col_r[9:0];
                col_nxt           = col_r + 11'd1;
              end else if (bpos_inc < lend_r) begin
                phase_nxt = PH_RUN_COUNT;
              end
            end
            need_end = (bpos_inc >= lend_r);
          end
          default: begin
            // count byte of a transparent run
            if (take != 11'd0) begin
              a_vld            = 1'b1;
              res_a.kind       = KIND_RUN;
              res_a.run_length = take;
              res_a.row        = row_r[9:0];
              res_a.column     = col_r[9:0];
            end
            col_nxt   = col_r + take;
            phase_nxt = PH_PAYLOAD;
            need_end  = (bpos_inc >= lend_r);
          end
        endcase
      end
    end

    // end of row: fill the rest with transparent pixels
    if (need_end) begin
      if (col_nxt < cfg.width) begin
        b_vld            = 1'b1;
        res_b.kind       = KIND_RUN;
        res_b.run_length = cfg.width - col_nxt;
        res_b.row        = row_r[9:0];
        res_b.column     = col_nxt[9:0];
      end
      row_nxt    = row_r + 11'd1;
      col_nxt    = '0;
      need_start = 1'b1;
    end

    // start of row: frame done when rows or bytes run out
    if (need_start) begin
      phase_nxt = PH_LEN_LO;
      if ((row_nxt >= cfg.height) ||
          (({1'b0, bpos_nxt} + LEN_BYTES) > {1'b0, cfg.stream_bytes})) begin
        fin_nxt          = 1'b1;
        c_vld            = 1'b1;
        left             = (cfg.height > row_nxt) ? (cfg.height - row_nxt) : 11'd0;
        res_c.kind       = KIND_DONE;
        res_c.run_length = left;
        res_c.row        = (left != 11'd0) ? row_nxt[9:0] : 10'd0;
      end
    end

    // pack results in order, tag the final one
    push.res = '0;
    n        = 2'd0;
    if (a_vld) begin
      push.res[n] = res_a;
      n = n + 2'd1;
    end
    if (b_vld) begin
      push.res[n] = res_b;
      n = n + 2'd1;
    end
    if (c_vld) begin
      push.res[n] = res_c;
      n = n + 2'd1;
    end
    if (n != 2'd0) begin
      push.res[n - 2'd1].last = 1'b1;
    end
    push.count = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEN_LO;
      bpos_r  <= '0;
      lend_r  <= '0;
      lenlo_r <= '0;
      col_r   <= '0;
      row_r   <= '0;
      fin_r   <= 1'b1;
    end else begin
      phase_r <= phase_nxt;
      bpos_r  <= bpos_nxt;
      lend_r  <= lend_nxt;
      lenlo_r <= lenlo_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

@@ design/srle_res_queue.sv @@
// ----------------------------------------------------------------------------
// srle_res_queue: result word queue
// Takes up to three result words per cycle, hands out one per cycle while popped.
// ----------------------------------------------------------------------------
module srle_res_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  srle_pkg::push_t   push,
  input  logic              pop,
  output logic              room,
  output logic              not_empty,
  output srle_pkg::result_t head
);
  import srle_pkg::*;

  result_t               mem [2**QUEUE_AW];
  logic [QUEUE_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QUEUE_CW-1:0]   cnt_r;

  assign room      = (cnt_r <= QUEUE_ROOM_MAX);
  assign not_empty = (cnt_r != '0);
  assign head      = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push.count) begin
        mem[wr_ptr_r + QUEUE_AW'(i)] <= push.res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QUEUE_AW'(push.count);
      rd_ptr_r <= rd_ptr_r + QUEUE_AW'(pop);
      cnt_r    <= cnt_r + QUEUE_CW'(push.count) - QUEUE_CW'(pop);
    end
  end

endmodule

@@ design/scanline_rle_sprite_decoder_top.sv @@
// ----------------------------------------------------------------------------
// scanline_rle_sprite_decoder_top: per-row zero-run RLE sprite decoder
// Takes one compressed byte per word and emits pixel runs, frame done and
// error words.
// ----------------------------------------------------------------------------
// Throughput: one input word per cycle while in_tready is high; result words leave
// one per cycle while out_tready is high. Results are registered in the result queue.
// A word makes 0 to 3 results; in_tready drops while the 8-entry result
//   queue has fewer than 3 free slots, so sustained rate is set by its drain.
// Reset (rst_n low, synchronous): queue empty, decoder idle until a start
//   word, registers back to width 1, height 1, stream size 0.
// ----------------------------------------------------------------------------
module scanline_rle_sprite_decoder_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] mode: 0 start frame, 1 data byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] pixel_value, [18:8] run_length,
                                  // [28:19] row, [38:29] column, [39] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [23:0] cfg_wdata
);
  import srle_pkg::*;

  // clamp limits, widened to 17 bits for the compare with the 11-bit registers
  localparam logic [16:0] MaxW = 17'(MAX_WIDTH);
  localparam logic [16:0] MaxH = 17'(MAX_HEIGHT);

  logic [10:0] frame_width_r;
  logic [10:0] frame_height_r;
  logic [23:0] stream_bytes_r;

  frame_cfg_t  cfg;
  push_t       push;
  result_t     head;
  logic        acc, pop, room, not_empty;

  // Config registers: written whenever cfg_we is high, read live by the decoder.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 11'd1;
      frame_height_r <= 11'd1;
      stream_bytes_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[10:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[10:0];
        REG_STREAM_BYTES: stream_bytes_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective frame size, clamped to the build-time maximum
  assign cfg.width  = ({6'd0, frame_width_r} < MaxW) ? frame_width_r : MaxW[10:0];
  assign cfg.height = ({6'd0, frame_height_r} < MaxH) ? frame_height_r : MaxH[10:0];
  assign cfg.stream_bytes = stream_bytes_r;

  // accept only with room for the worst case of three results
  assign in_tready = rst_n & room;
  assign acc       = in_tvalid & in_tready;
  assign pop       = out_tvalid & out_tready;

  srle_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .mode    (in_tuser[0]),
    .in_byte (in_tdata),
    .cfg     (cfg),
    .push    (push)
  );

  srle_res_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .room      (room),
    .not_empty (not_empty),
    .head      (head)
  );

  assign out_tvalid = not_empty;
  assign out_tdata  = {1'b0, head.column, head.row, head.run_length, head.pixel_value};
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last;

endmodule

@@ design/srle_checker.sv @@
// ----------------------------------------------------------------------------
// srle_checker: port-level checks of the sprite decoder
// Watches the top level's ports only; attached by bind.
// ----------------------------------------------------------------------------
module srle_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);
  import srle_pkg::*;

  // a stalled result word stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // no results straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word after reset");

  // done and error words carry pixel 0 at column 0 and end their word's results
  a_status_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_DONE || out_tuser == KIND_ERROR) |->
      out_tdata[TD_PIX_LSB +: 8] == 8'd0 && out_tdata[TD_COL_LSB +: 10] == 10'd0
      && out_tlast)
    else $error("bad status word");

  // kind code is never the unused one, pad bit stays zero
  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == KIND_RUN || out_tuser == KIND_DONE ||
                    out_tuser == KIND_ERROR) && !out_tdata[39])
    else $error("bad kind code");

endmodule

bind scanline_rle_sprite_decoder_top srle_checker u_srle_checker (.*);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for scanline_rle_sprite_decoder_top
// Feeds frame-start and compressed data words, predicts the run, frame done
// and error words in a local decoder copy, and checks every result word in
// order. Both stream sides idle at random; the result side also holds off for
// long stretches to back the block up.
// ----------------------------------------------------------------------------
module testbench;
  import srle_pkg::*;

  localparam int          MAX_W       = 1024;
  localparam int          MAX_H       = 1024;
  localparam logic        MODE_START  = 1'b0;
  localparam logic        MODE_DATA   = 1'b1;
  localparam int          SETTLE      = 8;       // quiet cycles before a register write
  localparam int          LONG_HOLD   = 250;     // receiver back-pressure stretch
  localparam int          CYCLE_LIMIT = 600000;
  localparam logic [23:0] STREAM_MAX  = 24'hFFFFFF;

  // decoder position within a row
  typedef enum logic [1:0] {
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD,
    PH_RUN_COUNT
  } row_phase_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] data;
  } stream_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;    // [7:0] data_byte
  logic [0:0]  in_tuser = '0;    // [0] mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;        // [7:0] pixel, [18:8] run, [28:19] row, [38:29] col
  logic [1:0]  out_tuser;        // [1:0] kind
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [23:0] cfg_wdata = '0;

  scanline_rle_sprite_decoder_top #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Decoder copy: register shadows and per-frame state, reset values
  // --------------------------------------------------------------------------
  logic [10:0] reg_width  = 11'd1;
  logic [10:0] reg_height = 11'd1;
  logic [23:0] reg_stream = '0;

  row_phase_t  dec_phase    = PH_LEN_LO;
  logic [23:0] dec_pos      = '0;    // bytes consumed since frame start
  logic [23:0] dec_row_stop = '0;    // position of the last byte of this row
  logic [7:0]  dec_len_lo   = '0;
  logic [10:0] dec_col      = '0;
  logic [10:0] dec_row      = '0;
  logic        dec_idle     = 1'b1;  // no frame running, data ignored

  result_t     word_runs[$];         // results of the word being decoded
  result_t     decoded_runs[$];      // predicted results not yet seen on out_*
  stream_word_t byte_stream[$];      // words waiting for the driver

  int          words_queued = 0;
  int          words_taken  = 0;
  int          mismatches   = 0;
  int          cycle_count  = 0;

  function automatic int unsigned used_width();
    return (int'(reg_width) < MAX_W) ? int'(reg_width) : MAX_W;
  endfunction

  function automatic int unsigned used_height();
    return (int'(reg_height) < MAX_H) ? int'(reg_height) : MAX_H;
  endfunction

  function automatic void add_run(input logic [1:0] kind, input logic [7:0] pix,
                                  input int unsigned len, input int unsigned row,
                                  input int unsigned col);
    result_t r;
    r.kind        = kind;
    r.pixel_value = pix;
    r.run_length  = len[10:0];
    r.row         = row[9:0];
    r.column      = col[9:0];
    r.last        = 1'b0;
    word_runs.push_back(r);
  endfunction

  // frame done: remaining rows reported as one transparent block
  function automatic void finish_frame();
    int unsigned h;
    int unsigned left;
    h    = used_height();
    left = (h > int'(dec_row)) ? h - int'(dec_row) : 0;
    dec_idle = 1'b1;
    add_run(KIND_DONE, 8'd0, left, (left != 0) ? int'(dec_row) : 0, 0);
  endfunction

  // row start: out of rows, or not even a length prefix left in the stream
  function automatic void begin_row();
    dec_phase = PH_LEN_LO;
    if (int'(dec_row) >= used_height()) begin
      finish_frame();
    end else if (int'(dec_pos) + int'(LEN_BYTES) > int'(reg_stream)) begin
      finish_frame();
    end
  endfunction

  // row end: pad the unfilled part with one transparent run
  function automatic void close_row();
    int unsigned w;
    w = used_width();
    if (int'(dec_col) < w) begin
      add_run(KIND_RUN, 8'd0, w - int'(dec_col), dec_row, dec_col);
    end
    dec_row = dec_row + 11'd1;
    dec_col = '0;
    begin_row();
  endfunction

  function automatic void decode_word(input logic mode, input logic [7:0] b);
    int unsigned w;
    int unsigned len;
    int unsigned row_stop;
    int unsigned room;
    int unsigned take;
    result_t     r;
    word_runs.delete();
    if (mode == MODE_START) begin
      dec_pos      = '0;
      dec_row_stop = '0;
      dec_len_lo   = '0;
      dec_col      = '0;
      dec_row      = '0;
      dec_idle     = 1'b0;
      begin_row();
    end else if (!dec_idle) begin
      w       = used_width();
      dec_pos = dec_pos + 24'd1;
      case (dec_phase)
        PH_LEN_LO: begin
          dec_len_lo = b;
          dec_phase  = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len      = {16'd0, b, dec_len_lo};
          // length counts its own two bytes; below two means empty payload
          row_stop = int'(dec_pos) + ((len >= int'(LEN_BYTES)) ? len - int'(LEN_BYTES) : 0);
          if (row_stop > int'(reg_stream)) begin
            dec_idle = 1'b1;
            add_run(KIND_ERROR, 8'd0, 0, dec_row, 0);
          end else begin
            dec_row_stop = row_stop[23:0];
            dec_phase    = PH_PAYLOAD;
            if (dec_pos >= dec_row_stop) close_row();
          end
        end
        PH_PAYLOAD: begin
          // bytes past the row width are consumed silently
          if (int'(dec_col) < w) begin
            if (b != 8'd0) begin
              add_run(KIND_RUN, b, 1, dec_row, dec_col);
              dec_col = dec_col + 11'd1;
            end else if (dec_pos < dec_row_stop) begin
              dec_phase = PH_RUN_COUNT;
            end
          end
          if (dec_pos >= dec_row_stop) close_row();
        end
        default: begin
          // transparent run, clipped to what is left of the row
          room = (int'(dec_col) < w) ? w - int'(dec_col) : 0;
          take = (int'(b) < room) ? int'(b) : room;
          if (take > 0) begin
            add_run(KIND_RUN, 8'd0, take, dec_row, dec_col);
            dec_col = dec_col + take[10:0];
          end
          dec_phase = PH_PAYLOAD;
          if (dec_pos >= dec_row_stop) close_row();
        end
      endcase
    end
    foreach (word_runs[i]) begin
      r      = word_runs[i];
      r.last = (i == word_runs.size() - 1);
      decoded_runs.push_back(r);
    end
  endfunction

  // idle length: mostly none or short, now and then long; none while steady
  function automatic int pick_gap(input logic steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents queued words, decodes each one as it is accepted
  // --------------------------------------------------------------------------
  int   send_gap   = 0;
  logic src_steady = 1'b0;

  always @(posedge clk) begin : feed
    stream_word_t nxt;
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      send_gap   <= 0;
      src_steady <= 1'b0;
    end else begin
      if ($urandom_range(0, 149) == 0) src_steady <= ~src_steady;
      if (in_tvalid && in_tready) begin
        decode_word(in_tuser[0], in_tdata);
        words_taken <= words_taken + 1;
      end
      // slot is free when nothing is offered or the offer was just taken
      if (!in_tvalid || in_tready) begin
        if (send_gap != 0) begin
          in_tvalid <= 1'b0;
          send_gap  <= send_gap - 1;
        end else if (byte_stream.size() != 0) begin
          nxt = byte_stream.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= nxt.mode;
          in_tdata  <= nxt.data;
          send_gap  <= pick_gap(src_steady);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver ready: random stalls after each word, plus two long hold-offs
  // while the sender keeps offering, so the result queue fills and in_tready
  // drops
  // --------------------------------------------------------------------------
  int   sink_gap    = 0;
  int   sink_hold   = 0;
  int   holds_done  = 0;
  logic sink_steady = 1'b0;

  always @(posedge clk) begin : sink
    int gap;
    if (!rst_n) begin
      out_tready  <= 1'b0;
      sink_gap    <= 0;
      sink_hold   <= 0;
      holds_done  <= 0;
      sink_steady <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) sink_steady <= ~sink_steady;
      if (sink_hold != 0) begin
        out_tready <= 1'b0;
        sink_hold  <= sink_hold - 1;
      end else if (holds_done < 2 && words_taken >= ((holds_done == 0) ? 60 : 300)) begin
        out_tready <= 1'b0;
        sink_hold  <= LONG_HOLD;
        holds_done <= holds_done + 1;
      end else if (sink_gap != 0) begin
        out_tready <= 1'b0;
        sink_gap   <= sink_gap - 1;
      end else if (out_tready && out_tvalid) begin
        gap = pick_gap(sink_steady);
        out_tready <= (gap == 0);
        sink_gap   <= (gap == 0) ? 0 : gap - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every accepted result word against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check
    result_t want;
    result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind        = out_tuser;
      got.pixel_value = out_tdata[7:0];
      got.run_length  = out_tdata[18:8];
      got.row         = out_tdata[28:19];
      got.column      = out_tdata[38:29];
      got.last        = out_tlast;
      if (decoded_runs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: kind %0d pix %0d run %0d row %0d col %0d last %0b",
                   got.kind, got.pixel_value, got.run_length, got.row, got.column, got.last);
      end else begin
        want = decoded_runs.pop_front();
        if (got !== want || out_tdata[39] !== 1'b0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at cycle %0d (pad bit %b)", cycle_count, out_tdata[39]);
            $display("  want kind %0d pix %0d run %0d row %0d col %0d last %0b",
                     want.kind, want.pixel_value, want.run_length, want.row, want.column,
                     want.last);
            $display("  got  kind %0d pix %0d run %0d row %0d col %0d last %0b",
                     got.kind, got.pixel_value, got.run_length, got.row, got.column,
                     got.last);
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_word(input logic mode, input logic [7:0] data);
    stream_word_t sw;
    sw.mode = mode;
    sw.data = data;
    byte_stream.push_back(sw);
    words_queued++;
  endtask

  // all words taken and every predicted result seen, then a SETTLE wait,
  // since a word with no result may still be in flight
  task automatic wait_idle();
    while (words_taken != words_queued || decoded_runs.size() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [23:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_FRAME_WIDTH:  reg_width  = val[10:0];
      REG_FRAME_HEIGHT: reg_height = val[10:0];
      REG_STREAM_BYTES: reg_stream = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_frame(input logic [23:0] w, input logic [23:0] h, input logic [23:0] s);
    set_reg(REG_FRAME_WIDTH, w);
    set_reg(REG_FRAME_HEIGHT, h);
    set_reg(REG_STREAM_BYTES, s);
  endtask

  // transparent run count: zero, full byte, any byte, or up to one past the row width
  function automatic logic [7:0] pick_count(input int w);
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'hFF;
    if (r < 4) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, (w + 1 > 255) ? 255 : w + 1));
  endfunction

  // one row: length prefix then pixels and zero-run pairs; wild rows may carry
  // a bogus length or a cut payload
  task automatic queue_row(input int w, input bit wild);
    logic [7:0]  body[$];
    logic [15:0] len;
    int          cap;
    int          target;
    int          sel;
    cap    = (w < 20) ? w + 3 : 24;
    target = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, cap);
    while (body.size() < target) begin
      if ($urandom_range(0, 3) == 0) begin
        body.push_back(8'd0);
        body.push_back(pick_count(w));
      end else begin
        body.push_back(8'($urandom_range(1, 255)));
      end
    end
    // dropping the last byte may leave a zero marker at the end of the row
    if (body.size() != 0 && $urandom_range(0, 5) == 0) void'(body.pop_back());
    len = 16'(body.size() + 2);
    sel = $urandom_range(0, 11);
    if (sel == 0) begin
      len = 16'($urandom_range(0, 2));
      if (!wild) body.delete();
    end else if (wild && sel == 1) begin
      len = 16'($urandom_range(0, 65535));
    end else if (wild && sel == 2 && body.size() > 1) begin
      void'(body.pop_back());
    end
    queue_word(MODE_DATA, len[7:0]);
    queue_word(MODE_DATA, len[15:8]);
    foreach (body[i]) queue_word(MODE_DATA, body[i]);
  endtask

  task automatic queue_frame(input int rows, input int w, input bit wild);
    queue_word(MODE_START, 8'($urandom));
    repeat (rows) queue_row(w, wild);
  endtask

  // frames with random content, wild rows if asked, about one pick in ten a lone noise word
  task automatic run_phase(input int w, input int rows_max, input bit wild, input int quota);
    int stop;
    stop = words_queued + quota;
    while (words_queued < stop) begin
      if ($urandom_range(0, 9) == 0)
        queue_word(($urandom_range(0, 7) == 0) ? MODE_START : MODE_DATA, 8'($urandom));
      else
        queue_frame($urandom_range(1, rows_max), w, wild);
    end
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int w;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: width 1, height 1, stream 0
    queue_word(MODE_DATA, 8'hA5);       // idle, ignored
    queue_word(MODE_START, 8'h3C);      // no room for a length: done at once
    wait_idle();

    set_frame(24'd4, 24'd3, 24'd64);
    queue_word(MODE_START, 8'h00);
    // row 0: pixel, zero run of 2, tail padded
    queue_word(MODE_DATA, 8'h05);
    queue_word(MODE_DATA, 8'h00);
    queue_word(MODE_DATA, 8'hFF);
    queue_word(MODE_DATA, 8'h00);
    queue_word(MODE_DATA, 8'h02);
    // row 1: length below two, whole row transparent
    queue_word(MODE_DATA, 8'h01);
    queue_word(MODE_DATA, 8'h00);
    // row 2: zero marker as the final byte, then frame done
    queue_word(MODE_DATA, 8'h04);
    queue_word(MODE_DATA, 8'h00);
    queue_word(MODE_DATA, 8'h07);
    queue_word(MODE_DATA, 8'h00);
    // length past the stream size
    queue_word(MODE_START, 8'hFF);
    queue_word(MODE_DATA, 8'hFF);
    queue_word(MODE_DATA, 8'hFF);
    // restart in the middle of a frame, then a run clipped at the width
    queue_word(MODE_START, 8'h00);
    queue_word(MODE_DATA, 8'h0A);
    queue_word(MODE_START, 8'h81);
    queue_word(MODE_DATA, 8'h06);
    queue_word(MODE_DATA, 8'h00);
    queue_word(MODE_DATA, 8'h01);
    queue_word(MODE_DATA, 8'h02);
    queue_word(MODE_DATA, 8'h00);
    queue_word(MODE_DATA, 8'hFF);
    wait_idle();

    // stream runs short at a row start
    set_frame(24'd2, 24'd4, 24'd6);
    queue_word(MODE_START, 8'h00);
    queue_word(MODE_DATA, 8'h03);
    queue_word(MODE_DATA, 8'h00);
    queue_word(MODE_DATA, 8'h09);
    queue_word(MODE_DATA, 8'h02);
    queue_word(MODE_DATA, 8'h00);
    wait_idle();

    // zero width, height and stream
    set_frame(24'd0, 24'd0, 24'd0);
    queue_word(MODE_START, 8'h00);
    wait_idle();

    // random part: small frames, full stream
    w = $urandom_range(1, 12);
    set_frame(24'(w), 24'($urandom_range(1, 6)), STREAM_MAX);
    run_phase(w, 6, 1'b0, 70);

    // largest frame, modest stream
    set_frame(24'd1024, 24'd1024, 24'($urandom_range(200, 4000)));
    run_phase(MAX_W, 4, 1'b0, 60);

    // sizes above the maximum are clamped
    set_frame(24'd2047, 24'd2047, STREAM_MAX);
    run_phase(MAX_W, 4, 1'b0, 50);

    // tiny stream, broken rows: errors and early frame ends
    w = $urandom_range(1, 8);
    set_frame(24'(w), 24'($urandom_range(2, 10)), 24'($urandom_range(8, 40)));
    run_phase(w, 3, 1'b1, 70);

    // zero width, then the width changes partway through the frame
    set_frame(24'd0, 24'd6, STREAM_MAX);
    queue_word(MODE_START, 8'h00);
    queue_row(0, 1'b0);
    queue_row(0, 1'b0);
    wait_idle();
    set_reg(REG_FRAME_WIDTH, 24'd5);
    repeat (3) queue_row(5, 1'b0);
    wait_idle();
    run_phase(5, 4, 1'b0, 40);

    wait_idle();
    if (mismatches == 0 && decoded_runs.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
